// ----- sv/gns_pkg.sv -----
// Shared types and constants for the grid negative spread step block.
// No dependencies; every other file in sv/ imports this package.
package gns_pkg;

  // Configuration port
  localparam int CFG_BITS       = 11;
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_HEIGHT = 2'd1;

  // Width of the row and column indexes on the result channel
  localparam int OUT_IDX_BITS = 10;

  // Result slots per item, in emission order
  localparam int NUM_SLOTS = 4;
  localparam int SLOT_BITS = 2;
  localparam logic [SLOT_BITS-1:0] SLOT_UP_LEFT = 2'd0;  // (r-1, c-1)
  localparam logic [SLOT_BITS-1:0] SLOT_UP      = 2'd1;  // (r-1, c)
  localparam logic [SLOT_BITS-1:0] SLOT_LEFT    = 2'd2;  // (r, c-1)
  localparam logic [SLOT_BITS-1:0] SLOT_HERE    = 2'd3;  // (r, c)

  // Where the current cell sits in the grid
  typedef struct packed {
    logic row_ge1;
    logic row_ge2;
    logic col_ge1;
    logic col_ge2;
    logic last_col;
    logic last_row;
  } pos_t;

endpackage

// ----- sv/gns_line_buf.sv -----
// Line stores: the previous row of cell values and the row-before-previous
// of negative marks. Uses gns_pkg.
module gns_line_buf #(
  parameter int MAX_WIDTH = 1024,
  parameter int CELL_BITS = 16,
  parameter int COL_BITS  = 10
) (
  input  logic                 clk,
  input  logic                 accept,
  input  logic [COL_BITS-1:0]  col,
  input  logic [CELL_BITS-1:0] cell_data,
  input  logic                 hold_valid,
  input  logic [COL_BITS-1:0]  hold_col,
  output logic [CELL_BITS-1:0] up_value,
  output logic                 up2_mark
);
  import gns_pkg::*;

  logic [CELL_BITS-1:0] value_mem [MAX_WIDTH];
  logic                 mark_mem  [MAX_WIDTH];

  // Read-first access at the accepted column: old row out, new row in.
  always_ff @(posedge clk) begin
    if (accept) begin
      up_value        <= value_mem[col];
      value_mem[col]  <= cell_data;
    end
  end

  // Push the held item's upper-row mark down one row. Forward it when the
  // next item reads the same column in the same edge (one-column grid).
  always_ff @(posedge clk) begin
    if (hold_valid) begin
      mark_mem[hold_col] <= up_value[CELL_BITS-1];
    end
    if (accept) begin
      if (hold_valid && (hold_col == col)) begin
        up2_mark <= up_value[CELL_BITS-1];
      end else begin
        up2_mark <= mark_mem[col];
      end
    end
  end

endmodule

// ----- sv/gns_window.sv -----
// 3x3 neighborhood test and value selection for the up-to-four cells that
// one item completes. Keeps the two previous columns. Uses gns_pkg.
module gns_window #(
  parameter int CELL_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 advance,
  input  logic [CELL_BITS-1:0]                 cell_data,
  input  logic [CELL_BITS-1:0]                 up_value,
  input  logic                                 up2_mark,
  input  gns_pkg::pos_t                        pos,
  output logic [gns_pkg::NUM_SLOTS-1:0]        mask,
  output logic [gns_pkg::NUM_SLOTS-1:0][CELL_BITS-1:0] values
);
  import gns_pkg::*;

  // Column history, same row, previous items
  logic                 tall_p1, tall_p2;   // three-row column ORs
  logic                 short_p1, short_p2; // two-row column ORs
  logic [CELL_BITS-1:0] up_p1;
  logic [CELL_BITS-1:0] cur_p1;

  logic tall_c, short_c;
  logic nb_up_left, nb_up, nb_left, nb_here;

  function automatic logic [CELL_BITS-1:0] spread(input logic [CELL_BITS-1:0] v,
                                                  input logic nb);
    logic positive;
    positive = !v[CELL_BITS-1] && (|v);
    return (positive && nb) ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    short_c = cell_data[CELL_BITS-1] | (pos.row_ge1 & up_value[CELL_BITS-1]);
    tall_c  = short_c | (pos.row_ge2 & up2_mark);

    nb_up_left = tall_c  | tall_p1  | (pos.col_ge2 & tall_p2);
    nb_up      = tall_c  | (pos.col_ge1 & tall_p1);
    nb_left    = short_c | short_p1 | (pos.col_ge2 & short_p2);
    nb_here    = short_c | (pos.col_ge1 & short_p1);

    mask[SLOT_UP_LEFT] = pos.row_ge1  & pos.col_ge1;
    mask[SLOT_UP]      = pos.row_ge1  & pos.last_col;
    mask[SLOT_LEFT]    = pos.last_row & pos.col_ge1;
    mask[SLOT_HERE]    = pos.last_row & pos.last_col;

    values[SLOT_UP_LEFT] = spread(up_p1, nb_up_left);
    values[SLOT_UP]      = spread(up_value, nb_up);
    values[SLOT_LEFT]    = spread(cur_p1, nb_left);
    values[SLOT_HERE]    = spread(cell_data, nb_here);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tall_p2  <= tall_p1;
      tall_p1  <= tall_c;
      short_p2 <= short_p1;
      short_p1 <= short_c;
      up_p1    <= up_value;
      cur_p1   <= cell_data;
    end
  end

endmodule

// ----- sv/gns_out_stage.sv -----
// Result register: holds the results of one item and hands them out one
// per cycle in slot order while result_stall is low. Uses gns_pkg.
module gns_out_stage #(
  parameter int CELL_BITS = 16,
  parameter int ROW_BITS  = 10,
  parameter int COL_BITS  = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  logic [gns_pkg::NUM_SLOTS-1:0]        load_mask,
  input  logic [gns_pkg::NUM_SLOTS-1:0][CELL_BITS-1:0] load_values,
  input  logic [ROW_BITS-1:0]                  load_row,
  input  logic [COL_BITS-1:0]                  load_col,
  input  logic                                 result_stall,
  output logic                                 result_valid,
  output logic [gns_pkg::OUT_IDX_BITS-1:0]     out_row,
  output logic [gns_pkg::OUT_IDX_BITS-1:0]     out_col,
  output logic signed [CELL_BITS-1:0]          out_value,
  output logic                                 last_in_run,
  output logic                                 grid_done,
  output logic                                 free
);
  import gns_pkg::*;

  logic [NUM_SLOTS-1:0]                mask;
  logic [NUM_SLOTS-1:0][CELL_BITS-1:0] values;
  logic [ROW_BITS-1:0]                 row;
  logic [COL_BITS-1:0]                 col;

  logic [SLOT_BITS-1:0] sel;
  logic [NUM_SLOTS-1:0] rest;
  logic [ROW_BITS-1:0]  row_sel;
  logic [COL_BITS-1:0]  col_sel;
  logic                 take;

  always_comb begin
    priority if (mask[SLOT_UP_LEFT]) sel = SLOT_UP_LEFT;
    else if (mask[SLOT_UP])          sel = SLOT_UP;
    else if (mask[SLOT_LEFT])        sel = SLOT_LEFT;
    else                             sel = SLOT_HERE;

    rest      = mask;
    rest[sel] = 1'b0;

    row_sel = ((sel == SLOT_UP_LEFT) || (sel == SLOT_UP)) ? row - 1'b1 : row;
    col_sel = ((sel == SLOT_UP_LEFT) || (sel == SLOT_LEFT)) ? col - 1'b1 : col;

    result_valid = |mask;
    take         = result_valid && !result_stall;
    last_in_run  = (rest == '0);
    grid_done    = (sel == SLOT_HERE);
    out_row      = OUT_IDX_BITS'(row_sel);
    out_col      = OUT_IDX_BITS'(col_sel);
    out_value    = values[sel];
    free         = !result_valid || (take && last_in_run);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= load_mask;
    end else if (take) begin
      mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      values <= load_values;
      row    <= load_row;
      col    <= load_col;
    end
  end

endmodule

// ----- sv/grid_negative_spread_step.sv -----
// Top level of the grid negative spread step: counters, configuration,
// input register. Uses gns_pkg, gns_line_buf, gns_window, gns_out_stage.
//
//   channel | handshake                   | payload
//   --------+-----------------------------+------------------------------------------------
//   cell    | cell_valid / cell_stall     | cell_value
//   result  | result_valid / result_stall | out_row out_col out_value last_in_run grid_done
//   config  | wr_en (no wait)             | wr_index wr_data
//
// Flow: an item is registered in the input register, then loads the result register,
// which gives one result per cycle while result_stall is low; items with 0 or 1 results
// stream at one per cycle, and an item with n > 1 results holds the next item back.
// Reset: clears counters, configuration (4 x 4) and valid flags; line stores
// keep their contents, and rows not yet written are masked out.
// Stalls: result_stall holds the result register, then the input register.
module grid_negative_spread_step #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int CELL_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                wr_en,
  input  logic [gns_pkg::CFG_INDEX_BITS-1:0]  wr_index,
  input  logic [gns_pkg::CFG_BITS-1:0]        wr_data,
  // cell channel
  input  logic                                cell_valid,
  output logic                                cell_stall,
  input  logic signed [CELL_BITS-1:0]         cell_value,
  // result channel
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [gns_pkg::OUT_IDX_BITS-1:0]    out_row,
  output logic [gns_pkg::OUT_IDX_BITS-1:0]    out_col,
  output logic signed [CELL_BITS-1:0]         out_value,
  output logic                                last_in_run,
  output logic                                grid_done
);
  import gns_pkg::*;

  localparam int COL_BITS = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int ROW_BITS = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Configuration registers
  logic [CFG_BITS-1:0] grid_width;
  logic [CFG_BITS-1:0] grid_height;

  // Raster position of the next item
  logic [ROW_BITS-1:0] row_count;
  logic [COL_BITS-1:0] col_count;

  // Input register
  logic                 s_valid;
  logic [CELL_BITS-1:0] s_cell;
  logic [ROW_BITS-1:0]  s_row;
  logic [COL_BITS-1:0]  s_col;
  pos_t                 s_pos;

  logic [COL_BITS-1:0] last_col_idx;
  logic [ROW_BITS-1:0] last_row_idx;
  logic [ROW_BITS-1:0] row_cur;
  logic [COL_BITS-1:0] col_cur;
  pos_t                pos_cur;
  logic                accept;
  logic                out_free;
  logic                load;

  logic [CELL_BITS-1:0]                up_value;
  logic                                up2_mark;
  logic [NUM_SLOTS-1:0]                win_mask;
  logic [NUM_SLOTS-1:0][CELL_BITS-1:0] win_values;

  // Effective last index: zero acts as one, oversize clamps to the maximum.
  always_comb begin
    if (grid_width == '0) begin
      last_col_idx = '0;
    end else if (32'(grid_width) > 32'(MAX_WIDTH)) begin
      last_col_idx = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      last_col_idx = COL_BITS'(32'(grid_width) - 32'd1);
    end
    if (grid_height == '0) begin
      last_row_idx = '0;
    end else if (32'(grid_height) > 32'(MAX_HEIGHT)) begin
      last_row_idx = ROW_BITS'(MAX_HEIGHT - 1);
    end else begin
      last_row_idx = ROW_BITS'(32'(grid_height) - 32'd1);
    end
  end

  // Restart at the origin if the counters stand outside the grid.
  always_comb begin
    if ((row_count > last_row_idx) || (col_count > last_col_idx)) begin
      row_cur = '0;
      col_cur = '0;
    end else begin
      row_cur = row_count;
      col_cur = col_count;
    end
    pos_cur.row_ge1  = (row_cur != '0);
    pos_cur.row_ge2  = (row_cur > ROW_BITS'(1));
    pos_cur.col_ge1  = (col_cur != '0);
    pos_cur.col_ge2  = (col_cur > COL_BITS'(1));
    pos_cur.last_col = (col_cur == last_col_idx);
    pos_cur.last_row = (row_cur == last_row_idx);
  end

  // Hold the input register while the result register still has results
  // that will not all be gone this cycle.
  assign load       = s_valid && out_free;
  assign cell_stall = s_valid && !out_free;
  assign accept     = cell_valid && !cell_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= CFG_BITS'(4);
      grid_height <= CFG_BITS'(4);
      row_count   <= '0;
      col_count   <= '0;
    end else if (wr_en) begin
      // Either register write restarts the grid.
      unique case (wr_index)
        CFG_GRID_WIDTH: begin
          grid_width <= wr_data;
          row_count  <= '0;
          col_count  <= '0;
        end
        CFG_GRID_HEIGHT: begin
          grid_height <= wr_data;
          row_count   <= '0;
          col_count   <= '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      // Advance in raster order, wrap at the grid end.
      if (pos_cur.last_col) begin
        col_count <= '0;
        row_count <= pos_cur.last_row ? '0 : row_cur + 1'b1;
      end else begin
        col_count <= col_cur + 1'b1;
        row_count <= row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end else if (load) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_cell <= cell_value;
      s_row  <= row_cur;
      s_col  <= col_cur;
      s_pos  <= pos_cur;
    end
  end

  gns_line_buf #(
    .MAX_WIDTH (MAX_WIDTH),
    .CELL_BITS (CELL_BITS),
    .COL_BITS  (COL_BITS)
  ) u_line_buf (
    .clk        (clk),
    .accept     (accept),
    .col        (col_cur),
    .cell_data  (cell_value),
    .hold_valid (s_valid),
    .hold_col   (s_col),
    .up_value   (up_value),
    .up2_mark   (up2_mark)
  );

  gns_window #(
    .CELL_BITS (CELL_BITS)
  ) u_window (
    .clk       (clk),
    .advance   (load),
    .cell_data (s_cell),
    .up_value  (up_value),
    .up2_mark  (up2_mark),
    .pos       (s_pos),
    .mask      (win_mask),
    .values    (win_values)
  );

  gns_out_stage #(
    .CELL_BITS (CELL_BITS),
    .ROW_BITS  (ROW_BITS),
    .COL_BITS  (COL_BITS)
  ) u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .load_mask    (win_mask),
    .load_values  (win_values),
    .load_row     (s_row),
    .load_col     (s_col),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_value    (out_value),
    .last_in_run  (last_in_run),
    .grid_done    (grid_done),
    .free         (out_free)
  );

endmodule
